### rtl/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared constants, handshake structs and status decode helpers.
// ----------------------------------------------------------------------------
package mbsp_pkg;

  localparam int DEF_SYSEX_DEPTH = 32;

  localparam logic [7:0]  ST_SYSEX  = 8'hF0;
  localparam logic [7:0]  ST_MTC    = 8'hF1;
  localparam logic [7:0]  ST_SPP    = 8'hF2;
  localparam logic [7:0]  ST_SONG   = 8'hF3;
  localparam logic [7:0]  ST_UNDEF4 = 8'hF4;
  localparam logic [7:0]  ST_UNDEF5 = 8'hF5;
  localparam logic [7:0]  ST_EOX    = 8'hF7;
  localparam logic [7:0]  ST_RT_MIN = 8'hF8;
  localparam logic [7:0]  ST_NONE   = 8'h00;
  localparam logic [3:0]  HI_PROG   = 4'hC;
  localparam logic [3:0]  HI_PRESS  = 4'hD;
  localparam logic [3:0]  HI_SYS    = 4'hF;
  localparam logic [15:0] DROP_MAX  = 16'hFFFF;
  localparam logic [4:0]  CHAN_SYS  = 5'd1;

  typedef struct packed {
    logic take;
    logic rd;
    logic push_dump;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skid_full;
    logic dump_start;
    logic dump_last;
  } dp_stat_t;

  function automatic logic [1:0] data_bytes_needed(input logic [7:0] st);
    logic [1:0] n;
    n = 2'd0;
    if (st[7]) begin
      case (st[7:4])
        HI_PROG, HI_PRESS: n = 2'd1;
        HI_SYS: begin
          if (st == ST_MTC || st == ST_SONG) n = 2'd1;
          else if (st == ST_SPP) n = 2'd2;
          else n = 2'd0;
        end
        default: n = 2'd2;
      endcase
    end
    return n;
  endfunction

  function automatic logic [7:0] msg_type_of(input logic [7:0] st);
    logic [7:0] t;
    if (st < ST_SYSEX) t = {st[7:4], 4'h0};
    else t = st;
    return t;
  endfunction

  function automatic logic [4:0] channel_of(input logic [7:0] st);
    logic [4:0] c;
    if (st < ST_SYSEX) c = {1'b0, st[3:0]} + 5'd1;
    else c = CHAN_SYS;
    return c;
  endfunction

endpackage

### rtl/mbsp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mbsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mbsp_ctrl.sv
// ----------------------------------------------------------------------------
// MIDI parser controller
// Sequences input acceptance and the SysEx dump readout.
// ----------------------------------------------------------------------------
module mbsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mbsp_pkg::dp_stat_t   stat,
  output mbsp_pkg::ctrl_cmd_t  cmd
);

  import mbsp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    in_stall      = (state != ST_IDLE) || stat.skid_full;
    cmd.take      = in_valid && !in_stall;
    cmd.rd        = (state == ST_READ);
    cmd.push_dump = (state == ST_WRITE) && !stat.skid_full;
    state_next    = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.take && stat.dump_start) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (cmd.push_dump) state_next = stat.dump_last ? ST_IDLE : ST_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/mbsp_dp.sv
// ----------------------------------------------------------------------------
// MIDI parser datapath
// Parser state, SysEx buffer, result assembly and two-word output buffer.
// ----------------------------------------------------------------------------
module mbsp_dp #(
  parameter int SYSEX_DEPTH = mbsp_pkg::DEF_SYSEX_DEPTH,
  localparam int IDX_W = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1,
  localparam int LEN_W = $clog2(SYSEX_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mbsp_pkg::ctrl_cmd_t  cmd,
  output mbsp_pkg::dp_stat_t   stat,
  input  logic [7:0]           rx_byte,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           msg_type,
  output logic [4:0]           channel,
  output logic [6:0]           data1,
  output logic [6:0]           data2,
  output logic [LEN_W-1:0]     sysex_length,
  output logic [IDX_W-1:0]     sysex_index,
  output logic [15:0]          overflow_count,
  output logic [2:0]           source,
  output logic                 last
);

  import mbsp_pkg::*;

  typedef struct packed {
    logic [7:0]       msg_type;
    logic [4:0]       channel;
    logic [6:0]       data1;
    logic [6:0]       data2;
    logic [LEN_W-1:0] sysex_length;
    logic [IDX_W-1:0] sysex_index;
    logic [15:0]      overflow_count;
    logic [2:0]       source;
    logic             last;
  } res_t;

  logic [2:0]       source_id;
  logic [7:0]       running_status, running_status_next;
  logic [7:0]       current_status, current_status_next;
  logic [1:0]       expected_count, expected_count_next;
  logic [1:0]       pending_count, pending_count_next;
  logic [6:0]       pending0, pending0_next;
  logic [6:0]       pending1, pending1_next;
  logic             in_sysex, in_sysex_next;
  logic [LEN_W-1:0] sysex_count, sysex_count_next;
  logic [15:0]      dropped_count, dropped_count_next;
  logic [LEN_W-1:0] dump_len;
  logic [IDX_W-1:0] dump_idx;

  logic             emit;
  logic             dump_start;
  logic             store_we;
  res_t             in_res;
  res_t             dump_res;
  res_t             push_res;
  logic             push;
  logic [6:0]       store_rdata;

  res_t             out_word;
  res_t             skid_word;
  logic             skid_valid;
  logic             out_free;

  logic [7:0]       cs_eff;
  logic [1:0]       ec_eff;
  logic [1:0]       pc_inc;

  mbsp_ram #(
    .WIDTH (7),
    .DEPTH (SYSEX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (sysex_count[IDX_W-1:0]),
    .wdata (rx_byte[6:0]),
    .re    (cmd.rd),
    .raddr (dump_idx),
    .rdata (store_rdata)
  );

  always_comb begin
    running_status_next = running_status;
    current_status_next = current_status;
    expected_count_next = expected_count;
    pending_count_next  = pending_count;
    pending0_next       = pending0;
    pending1_next       = pending1;
    in_sysex_next       = in_sysex;
    sysex_count_next    = sysex_count;
    dropped_count_next  = dropped_count;
    emit                = 1'b0;
    dump_start          = 1'b0;
    store_we            = 1'b0;
    cs_eff              = current_status;
    ec_eff              = expected_count;
    pc_inc              = (pending_count == 2'd3) ? 2'd3 : pending_count + 2'd1;

    in_res.msg_type       = rx_byte;
    in_res.channel        = CHAN_SYS;
    in_res.data1          = 7'd0;
    in_res.data2          = 7'd0;
    in_res.sysex_length   = '0;
    in_res.sysex_index    = '0;
    in_res.overflow_count = 16'd0;
    in_res.source         = source_id;
    in_res.last           = 1'b1;

    if (rx_byte >= ST_RT_MIN) begin
      emit = 1'b1;
    end else if (in_sysex && rx_byte == ST_EOX) begin
      in_sysex_next    = 1'b0;
      sysex_count_next = '0;
      if (sysex_count == '0) begin
        emit                  = 1'b1;
        in_res.msg_type       = ST_SYSEX;
        in_res.overflow_count = dropped_count;
      end else begin
        dump_start = 1'b1;
      end
    end else if (in_sysex && !rx_byte[7]) begin
      if (sysex_count < LEN_W'(SYSEX_DEPTH)) begin
        store_we         = 1'b1;
        sysex_count_next = sysex_count + LEN_W'(1);
      end else if (dropped_count != DROP_MAX) begin
        dropped_count_next = dropped_count + 16'd1;
      end
    end else begin
      if (in_sysex) begin
        in_sysex_next    = 1'b0;
        sysex_count_next = '0;
      end
      if (rx_byte[7]) begin
        if (rx_byte == ST_SYSEX) begin
          in_sysex_next       = 1'b1;
          sysex_count_next    = '0;
          pending_count_next  = 2'd0;
          running_status_next = ST_NONE;
          current_status_next = ST_NONE;
          expected_count_next = 2'd0;
        end else if (rx_byte == ST_EOX || rx_byte == ST_UNDEF4 || rx_byte == ST_UNDEF5) begin
          pending_count_next  = 2'd0;
          running_status_next = ST_NONE;
          current_status_next = ST_NONE;
          expected_count_next = 2'd0;
        end else begin
          current_status_next = rx_byte;
          pending_count_next  = 2'd0;
          expected_count_next = data_bytes_needed(rx_byte);
          running_status_next = (rx_byte < ST_SYSEX) ? rx_byte : ST_NONE;
          if (data_bytes_needed(rx_byte) == 2'd0) begin
            emit                = 1'b1;
            in_res.msg_type     = msg_type_of(rx_byte);
            in_res.channel      = channel_of(rx_byte);
            current_status_next = ST_NONE;
          end
        end
      end else if (current_status != ST_NONE || running_status != ST_NONE) begin
        if (current_status == ST_NONE) begin
          cs_eff = running_status;
          ec_eff = data_bytes_needed(running_status);
        end
        if (pending_count == 2'd0) pending0_next = rx_byte[6:0];
        if (pending_count == 2'd1) pending1_next = rx_byte[6:0];
        if (pc_inc >= ec_eff) begin
          emit            = 1'b1;
          in_res.msg_type = msg_type_of(cs_eff);
          in_res.channel  = channel_of(cs_eff);
          if (ec_eff >= 2'd1) begin
            in_res.data1 = (pending_count == 2'd0) ? rx_byte[6:0] : pending0;
          end
          if (ec_eff >= 2'd2) begin
            in_res.data2 = (pending_count == 2'd1) ? rx_byte[6:0] : pending1;
          end
          pending_count_next  = 2'd0;
          current_status_next = running_status;
          expected_count_next = data_bytes_needed(running_status);
        end else begin
          current_status_next = cs_eff;
          expected_count_next = ec_eff;
          pending_count_next  = pc_inc;
        end
      end
    end

    store_we = store_we && cmd.take;
  end

  always_comb begin
    dump_res.msg_type       = ST_SYSEX;
    dump_res.channel        = CHAN_SYS;
    dump_res.data1          = store_rdata;
    dump_res.data2          = 7'd0;
    dump_res.sysex_length   = dump_len;
    dump_res.sysex_index    = dump_idx;
    dump_res.overflow_count = dropped_count;
    dump_res.source         = source_id;
    dump_res.last           = stat.dump_last;
    push     = (cmd.take && emit) || cmd.push_dump;
    push_res = cmd.push_dump ? dump_res : in_res;
    out_free = !out_valid || !out_stall;
  end

  assign stat.skid_full  = skid_valid;
  assign stat.dump_start = dump_start;
  assign stat.dump_last  = (LEN_W'(dump_idx) + LEN_W'(1)) == dump_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_id      <= 3'd0;
      running_status <= ST_NONE;
      current_status <= ST_NONE;
      expected_count <= 2'd0;
      pending_count  <= 2'd0;
      pending0       <= 7'd0;
      pending1       <= 7'd0;
      in_sysex       <= 1'b0;
      sysex_count    <= '0;
      dropped_count  <= 16'd0;
      dump_len       <= '0;
      dump_idx       <= '0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        source_id <= cfg_data;
      end
      if (cmd.take) begin
        running_status <= running_status_next;
        current_status <= current_status_next;
        expected_count <= expected_count_next;
        pending_count  <= pending_count_next;
        pending0       <= pending0_next;
        pending1       <= pending1_next;
        in_sysex       <= in_sysex_next;
        sysex_count    <= sysex_count_next;
        dropped_count  <= dropped_count_next;
        if (dump_start) begin
          dump_len <= sysex_count;
          dump_idx <= '0;
        end
      end
      if (cmd.push_dump) begin
        dump_idx <= dump_idx + IDX_W'(1);
      end
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= push;
        end else begin
          out_valid  <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word  <= skid_word;
        skid_word <= push_res;
      end else begin
        out_word  <= push_res;
      end
    end else if (push) begin
      skid_word <= push_res;
    end
  end

  assign msg_type       = out_word.msg_type;
  assign channel        = out_word.channel;
  assign data1          = out_word.data1;
  assign data2          = out_word.data2;
  assign sysex_length   = out_word.sysex_length;
  assign sysex_index    = out_word.sysex_index;
  assign overflow_count = out_word.overflow_count;
  assign source         = out_word.source;
  assign last           = out_word.last;

endmodule

### rtl/midi_byte_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser unit
// Running-status MIDI parser with real-time pass-through and SysEx buffering.
//
//   channel   handshake             word
//   input     in_valid / in_stall   rx_byte
//   output    out_valid / out_stall msg_type .. last, one result per word
//   config    cfg_valid / cfg_ready cfg_data (source_id)
//
// An ordinary byte yields at most one word.
// A closing F7 of n stored bytes streams n words, each by a store read and
// then a buffer write; input is held off until the last word is written.
// Synchronous reset clears all parser state; the store needs no clearing pass.
// A two-word output buffer lets one byte in while a word waits under stall.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_unit #(
  parameter int SYSEX_DEPTH = mbsp_pkg::DEF_SYSEX_DEPTH,
  localparam int IDX_W = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1,
  localparam int LEN_W = $clog2(SYSEX_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       msg_type,
  output logic [4:0]       channel,
  output logic [6:0]       data1,
  output logic [6:0]       data2,
  output logic [LEN_W-1:0] sysex_length,
  output logic [IDX_W-1:0] sysex_index,
  output logic [15:0]      overflow_count,
  output logic [2:0]       source,
  output logic             last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_data
);

  import mbsp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  mbsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbsp_dp #(
    .SYSEX_DEPTH (SYSEX_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .rx_byte        (rx_byte),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .msg_type       (msg_type),
    .channel        (channel),
    .data1          (data1),
    .data2          (data2),
    .sysex_length   (sysex_length),
    .sysex_index    (sysex_index),
    .overflow_count (overflow_count),
    .source         (source),
    .last           (last)
  );

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser testbench
// Drives MIDI bytes through the parser with random gaps and output stalls.
// A local parser model predicts every output word, and a checker compares each
// word with the oldest prediction. Directed tests cover channel and system
// messages, running status, real-time bytes, lone status bytes and SysEx
// blocks. Two random streams follow, the second with no gaps or stalls, then a
// SysEx block that overflows the store. The source tag is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import mbsp_pkg::*;

  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_PROG     = 8'hC0;
  localparam logic [7:0] ST_PRESS    = 8'hD0;
  localparam logic [7:0] ST_BEND     = 8'hE0;
  localparam logic [7:0] ST_TUNE     = 8'hF6;
  localparam logic [7:0] ST_RT_STOP  = 8'hFC;
  localparam logic [7:0] ST_RT_MAX   = 8'hFF;
  localparam int SX_DEPTH     = DEF_SYSEX_DEPTH;
  localparam int SETTLE       = 40;
  localparam int STALL_PCT    = 26;
  localparam int WATCHDOG_MAX = 2000;

  typedef struct packed {
    logic [7:0]  kind;
    logic [4:0]  chan;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [5:0]  len;
    logic [4:0]  idx;
    logic [15:0] ovf;
    logic [2:0]  src;
    logic        fin;
  } midi_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  msg_type;
  logic [4:0]  channel;
  logic [6:0]  data1;
  logic [6:0]  data2;
  logic [5:0]  sysex_length;
  logic [4:0]  sysex_index;
  logic [15:0] overflow_count;
  logic [2:0]  source;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = 3'd0;
  logic        no_gaps = 1'b0;

  midi_word_t words_due[$];
  midi_word_t seen_word;
  midi_word_t due_word;
  int         mismatches = 0;
  int         bytes_sent = 0;
  int         quiet_cycles = 0;

  logic [2:0]  src_tag = 3'd0;
  logic [7:0]  run_st = ST_NONE;
  logic [7:0]  cur_st = ST_NONE;
  logic [1:0]  need_cnt = 2'd0;
  logic [1:0]  have_cnt = 2'd0;
  logic [6:0]  held[2];
  logic        sx_open = 1'b0;
  logic [5:0]  sx_cnt = 6'd0;
  logic [6:0]  sx_buf[SX_DEPTH];
  logic [15:0] drop_cnt = 16'd0;

  midi_byte_stream_parser_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .msg_type(msg_type),
    .channel(channel),
    .data1(data1),
    .data2(data2),
    .sysex_length(sysex_length),
    .sysex_index(sysex_index),
    .overflow_count(overflow_count),
    .source(source),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [1:0] data_len_of(input logic [7:0] st);
    if (!st[7]) return 2'd0;
    if (st < ST_SYSEX) return (st[7:4] == HI_PROG || st[7:4] == HI_PRESS) ? 2'd1 : 2'd2;
    if (st == ST_MTC || st == ST_SONG) return 2'd1;
    if (st == ST_SPP) return 2'd2;
    return 2'd0;
  endfunction

  function automatic void push_word(input logic [7:0] kind, input logic [4:0] chan,
                                    input logic [6:0] d1, input logic [6:0] d2,
                                    input logic [5:0] len, input logic [4:0] idx,
                                    input logic [15:0] ovf, input logic fin);
    midi_word_t w;
    w = '{kind, chan, d1, d2, len, idx, ovf, src_tag, fin};
    words_due.push_back(w);
  endfunction

  function automatic void emit_message(input logic [1:0] n);
    logic [7:0] kind;
    logic [4:0] chan;
    if (cur_st < ST_SYSEX) begin
      kind = {cur_st[7:4], 4'h0};
      chan = {1'b0, cur_st[3:0]} + 5'd1;
    end else begin
      kind = cur_st;
      chan = CHAN_SYS;
    end
    push_word(kind, chan, (n >= 2'd1) ? held[0] : 7'd0, (n >= 2'd2) ? held[1] : 7'd0,
              6'd0, 5'd0, 16'd0, 1'b1);
    have_cnt = 2'd0;
  endfunction

  function automatic void parse_midi_byte(input logic [7:0] b);
    if (b >= ST_RT_MIN) begin
      push_word(b, CHAN_SYS, 7'd0, 7'd0, 6'd0, 5'd0, 16'd0, 1'b1);
      return;
    end
    if (sx_open) begin
      if (b == ST_EOX) begin
        sx_open = 1'b0;
        if (sx_cnt == 6'd0)
          push_word(ST_SYSEX, CHAN_SYS, 7'd0, 7'd0, 6'd0, 5'd0, drop_cnt, 1'b1);
        else
          for (int i = 0; i < sx_cnt; i++)
            push_word(ST_SYSEX, CHAN_SYS, sx_buf[i], 7'd0, sx_cnt, 5'(i), drop_cnt,
                      (i + 1 == sx_cnt));
        sx_cnt = 6'd0;
        return;
      end
      if (b[7]) begin
        sx_open = 1'b0;
        sx_cnt = 6'd0;
      end else begin
        if (sx_cnt < SX_DEPTH) begin
          sx_buf[sx_cnt] = b[6:0];
          sx_cnt++;
        end else if (drop_cnt != DROP_MAX) begin
          drop_cnt++;
        end
        return;
      end
    end
    if (b[7]) begin
      if (b == ST_SYSEX) begin
        sx_open = 1'b1;
        sx_cnt = 6'd0;
        have_cnt = 2'd0;
        run_st = ST_NONE;
        cur_st = ST_NONE;
        need_cnt = 2'd0;
        return;
      end
      if (b == ST_EOX || b == ST_UNDEF4 || b == ST_UNDEF5) begin
        cur_st = ST_NONE;
        run_st = ST_NONE;
        have_cnt = 2'd0;
        need_cnt = 2'd0;
        return;
      end
      cur_st = b;
      have_cnt = 2'd0;
      need_cnt = data_len_of(b);
      run_st = (b < ST_SYSEX) ? b : ST_NONE;
      if (need_cnt == 2'd0) begin
        emit_message(2'd0);
        cur_st = ST_NONE;
      end
      return;
    end
    if (cur_st == ST_NONE) begin
      if (run_st == ST_NONE) return;
      cur_st = run_st;
      need_cnt = data_len_of(cur_st);
    end
    if (have_cnt < 2'd2) held[have_cnt[0]] = b[6:0];
    if (have_cnt < 2'd3) have_cnt++;
    if (have_cnt >= need_cnt) begin
      emit_message(need_cnt);
      cur_st = run_st;
      need_cnt = data_len_of(cur_st);
    end
  endfunction

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(99) < STALL_PCT);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (take_gap()) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_midi_byte(b);
    bytes_sent++;
  endtask

  task automatic send_list(input logic [7:0] seq[]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic set_source(input logic [2:0] id);
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= id;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    src_tag = id;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_data();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'h7F;
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic send_data_run(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 8) send_byte(8'($urandom_range(ST_RT_MIN, ST_RT_MAX)));
      send_byte(rand_data());
    end
  endtask

  task automatic test_channel_messages();
    send_list('{ST_NOTE_OFF | 8'h0F, 8'h00, 8'h7F, ST_PROG, 8'h7F});
  endtask

  task automatic test_running_status();
    send_list('{ST_BEND | 8'h07, 8'h7F, 8'h00, 8'h2A, 8'h55, ST_PRESS | 8'h03, 8'h11, 8'h22});
  endtask

  task automatic test_system_common();
    send_list('{ST_MTC, 8'h12, ST_SPP, 8'h01, 8'h7F, ST_TUNE, 8'h33});
  endtask

  task automatic test_realtime_and_lone();
    send_list('{ST_NOTE_ON | 8'h02, ST_RT_MIN, 8'h10, ST_RT_MAX, ST_UNDEF4, 8'h20,
                ST_UNDEF5, ST_EOX});
  endtask

  task automatic test_sysex_blocks();
    send_list('{ST_SYSEX, ST_EOX, ST_SYSEX, 8'h7F, ST_RT_STOP, 8'h00, ST_EOX, 8'h41,
                ST_SYSEX, 8'h11, ST_NOTE_ON | 8'h01, 8'h22, 8'h33});
  endtask

  task automatic test_random_stream(input int n);
    int first;
    int pick;
    int reps;
    int len;
    logic [7:0] st;
    first = bytes_sent;
    while (bytes_sent - first < n) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
        send_byte(st);
        reps = $urandom_range(0, 3);
        for (int r = 0; r <= reps; r++) send_data_run(data_len_of(st));
      end else if (pick < 52) begin
        case ($urandom_range(3))
          0: st = ST_MTC;
          1: st = ST_SPP;
          2: st = ST_SONG;
          default: st = ST_TUNE;
        endcase
        send_byte(st);
        len = data_len_of(st);
        if (len > 0 && $urandom_range(9) == 0) len--;
        send_data_run(len);
      end else if (pick < 75) begin
        send_byte(ST_SYSEX);
        len = ($urandom_range(99) < 15) ? $urandom_range(28, 40) : $urandom_range(0, 8);
        send_data_run(len);
        if ($urandom_range(99) < 85) send_byte(ST_EOX);
        else send_byte(8'($urandom_range(8'h80, ST_TUNE)));
      end else if (pick < 85) begin
        send_byte(8'($urandom_range(ST_RT_MIN, ST_RT_MAX)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_sysex_overflow();
    send_byte(ST_SYSEX);
    for (int k = 0; k < SX_DEPTH + 4; k++) send_byte(8'($urandom_range(0, 127)));
    send_byte(ST_EOX);
    send_list('{ST_SYSEX, 8'h5A, ST_EOX, ST_SYSEX, ST_EOX});
  endtask

  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < STALL_PCT);
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always begin
    @(posedge clk);
    if (!rst && out_valid && !out_stall) begin
      seen_word = '{msg_type, channel, data1, data2, sysex_length, sysex_index,
                    overflow_count, source, last};
      #1;
      if (words_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got %h", $time, seen_word);
      end else begin
        due_word = words_due.pop_front();
        check_field("msg_type", due_word.kind, seen_word.kind);
        check_field("channel", due_word.chan, seen_word.chan);
        check_field("data1", due_word.d1, seen_word.d1);
        check_field("data2", due_word.d2, seen_word.d2);
        check_field("sysex_length", due_word.len, seen_word.len);
        check_field("sysex_index", due_word.idx, seen_word.idx);
        check_field("overflow_count", due_word.ovf, seen_word.ovf);
        check_field("source", due_word.src, seen_word.src);
        check_field("last", due_word.fin, seen_word.fin);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_source(3'd5);
    test_channel_messages();
    test_running_status();
    test_system_common();
    test_realtime_and_lone();
    test_sysex_blocks();
    set_source(3'd0);
    test_random_stream(35);
    set_source(3'd7);
    no_gaps <= 1'b1;
    test_random_stream(35);
    set_source(3'd2);
    no_gaps <= 1'b0;
    test_sysex_overflow();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
